// File: src/djm_pkg.sv
// Package for the delta-R jet matcher: sizes, codes, configuration record and
// the transaction record that travels along the matching chain.
// Depends on nothing; every other file of the block imports it.
package djm_pkg;

   localparam int MAX_OFF_JETS = 16;
   localparam int PI_UNITS     = 804;

   localparam int PT_W     = 16;
   localparam int ETA_W    = 12;
   localparam int ETAMAX_W = 11;
   localparam int PHI_W    = 11;
   localparam int DISC_W   = 16;
   localparam int DRSQ_W   = 23;
   localparam int MIDX_W   = 4;
   localparam int FUNC_W   = 2;

   localparam int IDX_W    = (MAX_OFF_JETS > 1) ? $clog2(MAX_OFF_JETS) : 1;
   localparam int CNT_W    = $clog2(MAX_OFF_JETS + 1);
   localparam int TWO_PI   = 2 * PI_UNITS;
   localparam int DP_W     = ($clog2(TWO_PI + 1) > PHI_W + 1) ? $clog2(TWO_PI + 1) : PHI_W + 1;
   localparam int ESQ_W    = 2 * ETA_W;
   localparam int PSQ_W    = 2 * DP_W;
   localparam int D_W      = ((ESQ_W > PSQ_W) ? ESQ_W : PSQ_W) + 1;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 23;

   localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_LOAD  = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_QUERY = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_PT_MIN        = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ETA_MAX       = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DISC_FLOOR    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_TAG_THRESHOLD = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_DR_MAX_SQ     = 3'd4;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SQUARE,
      ST_SCAN,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [PT_W-1:0]          pt_min;
      logic [ETAMAX_W-1:0]      eta_max;
      logic signed [DISC_W-1:0] disc_floor;
      logic signed [DISC_W-1:0] tag_threshold;
      logic [DRSQ_W-1:0]        dr_max_sq;
   } cfg_type;

   typedef struct packed {
      logic                     valid;
      logic                     sel;
      logic                     tag;
      logic                     found;
      logic [D_W-1:0]           best_d;
      logic [IDX_W-1:0]         best_idx;
      logic signed [DISC_W-1:0] best_disc;
   } token_type;

endpackage

// File: src/djm_cuts.sv
// Selection cuts and tag decision for one online jet.
// Depends on djm_pkg for widths and the configuration record.
module djm_cuts import djm_pkg::*; (
   input  cfg_type                  cfg,
   input  logic [PT_W-1:0]          jet_pt,
   input  logic signed [ETA_W-1:0]  jet_eta,
   input  logic signed [DISC_W-1:0] jet_disc,
   output logic                     sel,
   output logic                     tag
);

   logic [ETA_W-1:0] eta_bits;
   logic [ETA_W-1:0] eta_mag;

   always_comb begin
      eta_bits = jet_eta;
      eta_mag  = eta_bits[ETA_W-1] ? (~eta_bits + ETA_W'(1)) : eta_bits;
      sel      = (jet_pt >= cfg.pt_min) && (eta_mag <= ETA_W'(cfg.eta_max))
                 && (jet_disc >= cfg.disc_floor);
      tag      = jet_disc > cfg.tag_threshold;
   end

endmodule

// File: src/djm_cell.sv
// One cell of the matching chain: holds one offline jet, squares its distance
// to the current online jet and updates the best match passing through it.
// Depends on djm_pkg for widths and the chain transaction record.
module djm_cell import djm_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     load_en,
   input  logic signed [ETA_W-1:0]  load_eta,
   input  logic signed [PHI_W-1:0]  load_phi,
   input  logic signed [DISC_W-1:0] load_disc,
   input  logic                     sq_en,
   input  logic signed [ETA_W-1:0]  q_eta,
   input  logic signed [PHI_W-1:0]  q_phi,
   input  logic                     active,
   input  logic [IDX_W-1:0]         cell_idx,
   input  token_type                tok_in,
   output token_type                tok_out
);

   logic signed [ETA_W-1:0]  eta_ff;
   logic signed [PHI_W-1:0]  phi_ff;
   logic signed [DISC_W-1:0] disc_ff;
   logic [ESQ_W-1:0]         eta_sq_ff;
   logic [ESQ_W-1:0]         eta_sq_in;
   logic [PSQ_W-1:0]         phi_sq_ff;
   logic [PSQ_W-1:0]         phi_sq_in;
   logic                     valid_ff;
   token_type                tok_ff;
   token_type                tok_in_next;

   logic signed [ETA_W:0]    de;
   logic signed [2*ETA_W+1:0] de_prod;
   logic [PHI_W:0]           dphi;
   logic [PHI_W:0]           dphi_mag;
   logic [DP_W-1:0]          dp_u;
   logic signed [DP_W+1:0]   wrap;
   logic [DP_W+1:0]          wrap_mag;
   logic [DP_W-1:0]          dp_fin;
   logic [D_W-1:0]           dist_sq;
   logic                     take;

   always_comb begin
      de       = {eta_ff[ETA_W-1], eta_ff} - {q_eta[ETA_W-1], q_eta};
      de_prod  = de * de;
      eta_sq_in = de_prod[ESQ_W-1:0];

      dphi     = {phi_ff[PHI_W-1], phi_ff} - {q_phi[PHI_W-1], q_phi};
      dphi_mag = dphi[PHI_W] ? (~dphi + (PHI_W+1)'(1)) : dphi;
      dp_u     = DP_W'(dphi_mag);
      wrap     = signed'((DP_W+2)'(TWO_PI)) - signed'({2'b00, dp_u});
      wrap_mag = wrap[DP_W+1] ? (~wrap + (DP_W+2)'(1)) : wrap;
      dp_fin   = (dp_u > DP_W'(PI_UNITS)) ? wrap_mag[DP_W-1:0] : dp_u;
      phi_sq_in = PSQ_W'(dp_fin) * PSQ_W'(dp_fin);
   end

   always_comb begin
      dist_sq = D_W'(eta_sq_ff) + D_W'(phi_sq_ff);
      take = tok_in.valid && tok_in.sel && active && (dist_sq < tok_in.best_d);
      tok_in_next = tok_in;
      if (take) begin
         tok_in_next.found     = 1'b1;
         tok_in_next.best_d    = dist_sq;
         tok_in_next.best_idx  = cell_idx;
         tok_in_next.best_disc = disc_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (load_en) begin
         eta_ff  <= load_eta;
         phi_ff  <= load_phi;
         disc_ff <= load_disc;
      end
      if (sq_en) begin
         eta_sq_ff <= eta_sq_in;
         phi_sq_ff <= phi_sq_in;
      end
      if (tok_in.valid) begin
         tok_ff <= tok_in_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= tok_in.valid;
      end
   end

   always_comb begin
      tok_out       = tok_ff;
      tok_out.valid = valid_ff;
   end

endmodule

// File: src/delta_r_jet_matcher_unit.sv
// Delta-R jet matcher top level: configuration registers, offline jet table as
// a chain of cells, query sequencer and the result register.
// Depends on djm_pkg, djm_cuts and djm_cell.
//
// Clear and load transactions produce no result; a load beyond MAX_OFF_JETS
// stored jets is dropped. After a query is accepted, every cell squares its
// eta and phi distance, then the best match travels one cell per cycle down
// the chain, then the result register is loaded once it is free. While a
// query is in the chain no new transaction is accepted; the result register
// lets the next transaction in while a finished result waits. Configuration
// writes are always ready and must only be made while the block is idle.
module delta_r_jet_matcher_unit import djm_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,

   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [FUNC_W-1:0]        req_func,
   input  logic [PT_W-1:0]          req_jet_pt,
   input  logic signed [ETA_W-1:0]  req_jet_eta,
   input  logic signed [PHI_W-1:0]  req_jet_phi,
   input  logic signed [DISC_W-1:0] req_jet_disc,

   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic                     rsp_selected,
   output logic                     rsp_matched,
   output logic [MIDX_W-1:0]        rsp_match_index,
   output logic [DRSQ_W-1:0]        rsp_match_dr_sq,
   output logic signed [DISC_W-1:0] rsp_offline_disc,
   output logic                     rsp_tagged_res,

   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [CSR_IDX_W-1:0]     csr_index,
   input  logic [CSR_DATA_W-1:0]    csr_data
);

   cfg_type                  cfg_ff;
   state_type                state_ff;
   state_type                state_in;
   logic [CNT_W-1:0]         count_ff;
   logic [CNT_W-1:0]         count_in;
   logic signed [ETA_W-1:0]  q_eta_ff;
   logic signed [PHI_W-1:0]  q_phi_ff;
   logic                     q_sel_ff;
   logic                     q_tag_ff;
   logic                     start_ff;
   logic                     start_in;
   logic                     rsp_valid_ff;
   logic                     rsp_valid_in;
   logic                     sel_now;
   logic                     tag_now;
   logic                     accepted;
   logic                     do_load;
   logic                     sq_en;
   logic                     load_rsp;
   logic                     rsp_free;
   logic [31:0]              idx_wide;
   token_type                tok [MAX_OFF_JETS+1];

   assign csr_ready = 1'b1;
   assign accepted  = req_valid && !req_stall;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign do_load   = accepted && (req_func == FUNC_LOAD)
                      && (count_ff < CNT_W'(MAX_OFF_JETS));

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pt_min        <= PT_W'(120);
         cfg_ff.eta_max       <= ETAMAX_W'(614);
         cfg_ff.disc_floor    <= -DISC_W'(5120);
         cfg_ff.tag_threshold <= DISC_W'(614);
         cfg_ff.dr_max_sq     <= DRSQ_W'(655);
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_PT_MIN:        cfg_ff.pt_min        <= csr_data[PT_W-1:0];
            CSR_ETA_MAX:       cfg_ff.eta_max       <= csr_data[ETAMAX_W-1:0];
            CSR_DISC_FLOOR:    cfg_ff.disc_floor    <= signed'(csr_data[DISC_W-1:0]);
            CSR_TAG_THRESHOLD: cfg_ff.tag_threshold <= signed'(csr_data[DISC_W-1:0]);
            CSR_DR_MAX_SQ:     cfg_ff.dr_max_sq     <= csr_data[DRSQ_W-1:0];
            default: ;
         endcase
      end
   end

   djm_cuts u_cuts (
      .cfg      (cfg_ff),
      .jet_pt   (req_jet_pt),
      .jet_eta  (req_jet_eta),
      .jet_disc (req_jet_disc),
      .sel      (sel_now),
      .tag      (tag_now)
   );

   always_comb begin
      count_in = count_ff;
      if (accepted && (req_func == FUNC_CLEAR)) begin
         count_in = '0;
      end else if (do_load) begin
         count_in = count_ff + CNT_W'(1);
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accepted && (req_func == FUNC_QUERY)) begin
               state_in = ST_SQUARE;
            end
         end
         ST_SQUARE: state_in = ST_SCAN;
         ST_SCAN: begin
            if (tok[MAX_OFF_JETS].valid) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_stall = 1'b1;
      sq_en     = 1'b0;
      load_rsp  = 1'b0;
      unique case (state_ff)
         ST_IDLE:   req_stall = 1'b0;
         ST_SQUARE: sq_en     = 1'b1;
         ST_SCAN:   ;
         ST_DONE:   load_rsp  = rsp_free;
         default:   ;
      endcase
   end

   assign start_in     = sq_en;
   assign rsp_valid_in = load_rsp ? 1'b1 : (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         start_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         start_ff     <= start_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accepted && (req_func == FUNC_QUERY)) begin
         q_eta_ff <= req_jet_eta;
         q_phi_ff <= req_jet_phi;
         q_sel_ff <= sel_now;
         q_tag_ff <= tag_now;
      end
   end

   always_comb begin
      tok[0].valid     = start_ff;
      tok[0].sel       = q_sel_ff;
      tok[0].tag       = q_tag_ff;
      tok[0].found     = 1'b0;
      tok[0].best_d    = D_W'(cfg_ff.dr_max_sq);
      tok[0].best_idx  = '0;
      tok[0].best_disc = '0;
   end

   for (genvar i = 0; i < MAX_OFF_JETS; i++) begin : g_cell
      djm_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .load_en   (do_load && (count_ff == CNT_W'(i))),
         .load_eta  (req_jet_eta),
         .load_phi  (req_jet_phi),
         .load_disc (req_jet_disc),
         .sq_en     (sq_en),
         .q_eta     (q_eta_ff),
         .q_phi     (q_phi_ff),
         .active    (CNT_W'(i) < count_ff),
         .cell_idx  (IDX_W'(i)),
         .tok_in    (tok[i]),
         .tok_out   (tok[i+1])
      );
   end

   assign idx_wide = 32'(tok[MAX_OFF_JETS].best_idx);

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp_selected     <= tok[MAX_OFF_JETS].sel;
         rsp_matched      <= tok[MAX_OFF_JETS].found;
         rsp_tagged_res   <= tok[MAX_OFF_JETS].tag;
         rsp_match_index  <= tok[MAX_OFF_JETS].found ? idx_wide[MIDX_W-1:0] : '0;
         rsp_match_dr_sq  <= tok[MAX_OFF_JETS].found
                             ? tok[MAX_OFF_JETS].best_d[DRSQ_W-1:0] : '0;
         rsp_offline_disc <= tok[MAX_OFF_JETS].found ? tok[MAX_OFF_JETS].best_disc : '0;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// File: tb/tb.sv
// Self-checking testbench for delta_r_jet_matcher_unit: a scoreboard class that predicts every
// query result from its own copy of the jet table and registers, plus tasks that drive the block.
// Depends on djm_pkg and the delta_r_jet_matcher_unit RTL.
module tb;
   import djm_pkg::*;

   localparam logic [FUNC_W-1:0] FUNC_SPARE = 2'd3;
   localparam int HOLD_CYCLES    = 300;
   localparam int DRAIN_CYCLES   = MAX_OFF_JETS + 8;
   localparam int WATCHDOG_LIMIT = 3000;

   typedef struct packed {
      logic                     selected;
      logic                     matched;
      logic [MIDX_W-1:0]        match_index;
      logic [DRSQ_W-1:0]        match_dr_sq;
      logic signed [DISC_W-1:0] offline_disc;
      logic                     tagged_res;
   } match_result_type;

   class jet_match_scoreboard_type;
      logic [PT_W-1:0]          pt_min;
      logic [ETAMAX_W-1:0]      eta_max;
      logic signed [DISC_W-1:0] disc_floor;
      logic signed [DISC_W-1:0] tag_threshold;
      logic [DRSQ_W-1:0]        dr_max_sq;
      logic signed [ETA_W-1:0]  tab_eta[MAX_OFF_JETS];
      logic signed [PHI_W-1:0]  tab_phi[MAX_OFF_JETS];
      logic signed [DISC_W-1:0] tab_disc[MAX_OFF_JETS];
      int                       tab_count;
      match_result_type         awaited_matches[$];
      int clears, loads, dropped, queries, ignored;
      int selected_n, matched_n, tagged_n, checked, mismatches;

      function new();
         pt_min        = 16'd120;
         eta_max       = 11'd614;
         disc_floor    = -16'sd5120;
         tag_threshold = 16'sd614;
         dr_max_sq     = 23'd655;
         tab_count     = 0;
      endfunction

      function void set_register(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            CSR_PT_MIN:        pt_min = data[PT_W-1:0];
            CSR_ETA_MAX:       eta_max = data[ETAMAX_W-1:0];
            CSR_DISC_FLOOR:    disc_floor = data[DISC_W-1:0];
            CSR_TAG_THRESHOLD: tag_threshold = data[DISC_W-1:0];
            CSR_DR_MAX_SQ:     dr_max_sq = data[DRSQ_W-1:0];
            default: ;
         endcase
      endfunction

      function void predict_match(logic [FUNC_W-1:0] func, logic [PT_W-1:0] pt,
                                  logic signed [ETA_W-1:0] eta, logic signed [PHI_W-1:0] phi,
                                  logic signed [DISC_W-1:0] disc);
         match_result_type r;
         int               eta_abs, de, dp, i;
         longint           d, best_d;
         case (func)
            FUNC_CLEAR: begin
               tab_count = 0;
               clears++;
            end
            FUNC_LOAD: begin
               loads++;
               if (tab_count < MAX_OFF_JETS) begin
                  tab_eta[tab_count]  = eta;
                  tab_phi[tab_count]  = phi;
                  tab_disc[tab_count] = disc;
                  tab_count++;
               end else begin
                  dropped++;
               end
            end
            FUNC_QUERY: begin
               queries++;
               r = '0;
               eta_abs = (eta < 0) ? -int'(eta) : int'(eta);
               r.selected = (pt >= pt_min) && (eta_abs <= int'(eta_max)) &&
                            (int'(disc) >= int'(disc_floor));
               r.tagged_res = int'(disc) > int'(tag_threshold);
               if (r.selected) begin
                  best_d = longint'(dr_max_sq);
                  for (i = 0; i < tab_count; i++) begin
                     de = int'(tab_eta[i]) - int'(eta);
                     dp = int'(tab_phi[i]) - int'(phi);
                     if (dp < 0) dp = -dp;
                     if (dp > PI_UNITS) dp = 2 * PI_UNITS - dp;
                     if (dp < 0) dp = -dp;
                     d = longint'(de) * de + longint'(dp) * dp;
                     if (d < best_d) begin
                        best_d         = d;
                        r.matched      = 1'b1;
                        r.match_index  = i[MIDX_W-1:0];
                        r.match_dr_sq  = best_d[DRSQ_W-1:0];
                        r.offline_disc = tab_disc[i];
                     end
                  end
               end
               selected_n += r.selected;
               matched_n  += r.matched;
               tagged_n   += r.tagged_res;
               awaited_matches = {awaited_matches, r};
            end
            default: ignored++;
         endcase
      endfunction

      function void check_match(match_result_type got);
         match_result_type want;
         if (awaited_matches.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("Result transaction arrived with no query outstanding: sel=%0b match=%0b",
                        got.selected, got.matched);
            return;
         end
         want = awaited_matches.pop_front();
         checked++;
         if (got.selected !== want.selected || got.matched !== want.matched ||
             got.match_index !== want.match_index || got.match_dr_sq !== want.match_dr_sq ||
             got.offline_disc !== want.offline_disc || got.tagged_res !== want.tagged_res) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("Result %0d expected sel=%0b match=%0b idx=%0d dr2=%0d disc=%0d tag=%0b",
                        checked, want.selected, want.matched, want.match_index,
                        want.match_dr_sq, want.offline_disc, want.tagged_res);
               $display("Result %0d actual   sel=%0b match=%0b idx=%0d dr2=%0d disc=%0d tag=%0b",
                        checked, got.selected, got.matched, got.match_index,
                        got.match_dr_sq, got.offline_disc, got.tagged_res);
            end
         end
      endfunction
   endclass

   logic                     clock;
   logic                     reset;
   logic                     req_valid;
   logic                     req_stall;
   logic [FUNC_W-1:0]        req_func;
   logic [PT_W-1:0]          req_jet_pt;
   logic signed [ETA_W-1:0]  req_jet_eta;
   logic signed [PHI_W-1:0]  req_jet_phi;
   logic signed [DISC_W-1:0] req_jet_disc;
   logic                     rsp_valid;
   logic                     rsp_stall;
   logic                     rsp_selected;
   logic                     rsp_matched;
   logic [MIDX_W-1:0]        rsp_match_index;
   logic [DRSQ_W-1:0]        rsp_match_dr_sq;
   logic signed [DISC_W-1:0] rsp_offline_disc;
   logic                     rsp_tagged_res;
   logic                     csr_valid;
   logic                     csr_ready;
   logic [CSR_IDX_W-1:0]     csr_index;
   logic [CSR_DATA_W-1:0]    csr_data;

   jet_match_scoreboard_type sb;
   match_result_type         got;
   bit                       idle_on = 1'b1;
   bit                       hold_request = 1'b0;
   bit                       hold_done = 1'b0;
   int                       items_sent = 0;
   int                       quiet = 0;

   delta_r_jet_matcher_unit dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_func(req_func),
      .req_jet_pt(req_jet_pt), .req_jet_eta(req_jet_eta), .req_jet_phi(req_jet_phi),
      .req_jet_disc(req_jet_disc),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_selected(rsp_selected),
      .rsp_matched(rsp_matched), .rsp_match_index(rsp_match_index),
      .rsp_match_dr_sq(rsp_match_dr_sq), .rsp_offline_disc(rsp_offline_disc),
      .rsp_tagged_res(rsp_tagged_res),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index), .csr_data(csr_data)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall)
            sb.predict_match(req_func, req_jet_pt, req_jet_eta, req_jet_phi, req_jet_disc);
         if (csr_valid && csr_ready)
            sb.set_register(csr_index, csr_data);
         if (rsp_valid && !rsp_stall) begin
            got.selected     = rsp_selected;
            got.matched      = rsp_matched;
            got.match_index  = rsp_match_index;
            got.match_dr_sq  = rsp_match_dr_sq;
            got.offline_disc = rsp_offline_disc;
            got.tagged_res   = rsp_tagged_res;
            sb.check_match(got);
         end
      end
   end

   // The receiver stalls at random, and once holds off for a long stretch to fill the block.
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request && !hold_done) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES - 1) @(negedge clock);
            hold_done = 1'b1;
         end else begin
            rsp_stall <= idle_on && ($urandom_range(0, 99) < 26);
         end
      end
   end

   initial begin
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("Timeout: no transaction for %0d cycles.", WATCHDOG_LIMIT);
      $display("CHECK FAILED");
      $finish;
   end

   task automatic send_item(input logic [FUNC_W-1:0] func, input int pt, input int eta,
                            input int phi, input int disc);
      @(negedge clock);
      while (idle_on && $urandom_range(0, 99) < 26) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid    <= 1'b1;
      req_func     <= func;
      req_jet_pt   <= PT_W'(pt);
      req_jet_eta  <= ETA_W'(eta);
      req_jet_phi  <= PHI_W'(phi);
      req_jet_disc <= DISC_W'(disc);
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (func != FUNC_SPARE) items_sent++;
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input int value, input int width);
      logic [CSR_DATA_W-1:0] data;
      data = CSR_DATA_W'(value) & ((CSR_DATA_W'(1) << width) - 1'b1);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   task automatic settle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (sb.awaited_matches.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // Events are a clear, a burst of loads and a few queries mostly aimed near stored jets.
   task automatic run_events(input int n_items, input int reach);
      logic signed [ETA_W-1:0] ev_eta[MAX_OFF_JETS];
      logic signed [PHI_W-1:0] ev_phi[MAX_OFF_JETS];
      int start, n_load, n_query, stored, pick, k, e, p, pt, disc, lim;
      start = items_sent;
      while (items_sent - start < n_items) begin
         if ($urandom_range(0, 99) < 88) begin
            send_item(FUNC_CLEAR, $urandom, $urandom, $urandom, $urandom);
            lim = int'(sb.eta_max) + 40;
            if ($urandom_range(0, 99) < 12)
               n_load = $urandom_range(MAX_OFF_JETS, MAX_OFF_JETS + 3);
            else
               n_load = $urandom_range(0, 10);
            stored = 0;
            for (k = 0; k < n_load; k++) begin
               if (stored > 0 && $urandom_range(0, 9) == 0) begin
                  pick = $urandom_range(0, stored - 1);
                  e = int'(ev_eta[pick]);
                  p = int'(ev_phi[pick]);
               end else if ($urandom_range(0, 9) == 0) begin
                  e = $urandom;
                  p = $urandom;
               end else begin
                  e = int'($urandom_range(0, 2 * lim)) - lim;
                  p = int'($urandom_range(0, 2 * PI_UNITS)) - PI_UNITS;
               end
               send_item(FUNC_LOAD, $urandom, e, p, $urandom);
               if (stored < MAX_OFF_JETS) begin
                  ev_eta[stored] = ETA_W'(e);
                  ev_phi[stored] = PHI_W'(p);
                  stored++;
               end
            end
            n_query = $urandom_range(1, 5);
            for (k = 0; k < n_query; k++) begin
               if (stored > 0 && $urandom_range(0, 99) < 75) begin
                  pick = $urandom_range(0, stored - 1);
                  e = int'(ev_eta[pick]) + int'($urandom_range(0, 2 * reach)) - reach;
                  p = int'(ev_phi[pick]) + int'($urandom_range(0, 2 * reach)) - reach;
                  if (p > PI_UNITS && $urandom_range(0, 9) != 0)
                     p -= 2 * PI_UNITS;
                  else if (p < -PI_UNITS && $urandom_range(0, 9) != 0)
                     p += 2 * PI_UNITS;
               end else begin
                  e = int'($urandom_range(0, 2 * lim)) - lim;
                  p = $urandom;
               end
               if ($urandom_range(0, 1) == 0)
                  pt = $urandom;
               else
                  pt = int'(sb.pt_min) + int'($urandom_range(0, 4)) - 2;
               case ($urandom_range(0, 4))
                  0:       disc = int'(sb.disc_floor) + int'($urandom_range(0, 2)) - 1;
                  1:       disc = int'(sb.tag_threshold) + int'($urandom_range(0, 2)) - 1;
                  default: disc = $urandom;
               endcase
               send_item(FUNC_QUERY, pt, e, p, disc);
            end
         end else begin
            send_item($urandom_range(0, 3), $urandom, $urandom, $urandom, $urandom);
         end
      end
   endtask

   task automatic run_phase(input int pt_min, input int eta_max, input int disc_floor,
                            input int tag_threshold, input int dr_max_sq, input int n_items,
                            input bit calm, input bit pressure);
      int reach;
      settle();
      write_reg(CSR_PT_MIN, pt_min, PT_W);
      write_reg(CSR_ETA_MAX, eta_max, ETAMAX_W);
      write_reg(CSR_DISC_FLOOR, disc_floor, DISC_W);
      write_reg(CSR_TAG_THRESHOLD, tag_threshold, DISC_W);
      write_reg(CSR_DR_MAX_SQ, dr_max_sq, DRSQ_W);
      idle_on = !calm;
      if (pressure) hold_request = 1'b1;
      @(negedge clock);
      csr_valid <= 1'b0;
      reach = 4;
      while (reach * reach < dr_max_sq && reach < 3000) reach++;
      reach = reach + reach / 4 + 4;
      run_events(n_items, reach);
   endtask

   initial begin
      int k;
      sb           = new();
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_func     = FUNC_CLEAR;
      req_jet_pt   = '0;
      req_jet_eta  = '0;
      req_jet_phi  = '0;
      req_jet_disc = '0;
      csr_valid    = 1'b0;
      csr_index    = CSR_PT_MIN;
      csr_data     = '0;
      repeat (8) @(negedge clock);
      reset <= 1'b0;

      // Directed transactions under the reset register values.
      send_item(FUNC_QUERY, 120, 614, 0, -5120);
      send_item(FUNC_QUERY, 119, 0, 0, 615);
      send_item(FUNC_QUERY, 65535, -615, 0, 0);
      send_item(FUNC_QUERY, 500, -614, 0, -5121);
      send_item(FUNC_SPARE, $urandom, $urandom, $urandom, $urandom);
      send_item(FUNC_CLEAR, 0, 0, 0, 0);
      send_item(FUNC_LOAD, 0, 0, 800, 32767);
      send_item(FUNC_LOAD, 0, 10, 0, -32768);
      send_item(FUNC_LOAD, 0, 10, 0, 1234);
      send_item(FUNC_LOAD, 0, -2048, -1024, 0);
      send_item(FUNC_QUERY, 65535, 0, -800, 0);
      send_item(FUNC_QUERY, 300, 10, 0, 614);
      send_item(FUNC_QUERY, 300, -614, 1023, 32767);
      for (k = 4; k < MAX_OFF_JETS; k++)
         send_item(FUNC_LOAD, 0, 600, 100 * k - 800, 1000 * k);
      send_item(FUNC_LOAD, 0, -300, -300, 7);
      send_item(FUNC_QUERY, 300, -300, -300, 0);

      run_phase(120, 614, -5120, 614, 655, 260, 1'b1, 1'b0);
      run_phase(0, 1280, -32768, 32767, 8388607, 220, 1'b0, 1'b0);
      run_phase(65535, 0, 32767, -32768, 0, 120, 1'b0, 1'b0);
      for (k = 0; k < 3; k++)
         run_phase($urandom_range(0, 300), $urandom_range(300, 1280),
                   -int'($urandom_range(0, 20000)), int'($urandom_range(0, 65535)) - 32768,
                   $urandom_range(100, 30000), 230, 1'b0, k == 0);
      settle();

      $display("Covered %0d clears, %0d loads (%0d dropped at a full table), %0d queries and %0d",
               sb.clears, sb.loads, sb.dropped, sb.queries, sb.ignored);
      $display("ignored items over seven register settings; %0d selected, %0d matched, %0d tagged.",
               sb.selected_n, sb.matched_n, sb.tagged_n);
      if (sb.mismatches == 0 && sb.awaited_matches.size() == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule

// File: files.f
src/djm_pkg.sv
src/djm_cuts.sv
src/djm_cell.sv
src/delta_r_jet_matcher_unit.sv
tb/tb.sv
